/* hw/rtl/sibs_pkg.sv */
// Shared types and constants for the sorted index binary search block.
package sibs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam int unsigned SIZE_W = 11;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned OFFS_W = 32;
  localparam int unsigned POS_W  = 11;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] search_key;
    logic [OFFS_W-1:0]       entry_offset;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [OFFS_W-1:0] match_offset;
  } out_word_t;

endpackage

/* hw/rtl/sibs_mem.sv */
// Key and offset storage: one write port, one read port, registered read data.
module sibs_mem import sibs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [KEY_W-1:0]  wr_key,
  input  logic [OFFS_W-1:0] wr_offs,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [KEY_W-1:0]  rd_key,
  output logic [OFFS_W-1:0] rd_offs
);

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [OFFS_W-1:0] offs_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      offs_mem[wr_addr] <= wr_offs;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_offs <= offs_mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/sibs_ctrl.sv */
// Search sequencer: slot loads, end checks and one memory probe per cycle.
module sibs_ctrl import sibs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned SW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  input  logic [SIZE_W-1:0] table_size,
  output logic              res_valid,
  input  logic              res_ready,
  output out_word_t         res_word,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [KEY_W-1:0]  wr_key,
  output logic [OFFS_W-1:0] wr_offs,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [KEY_W-1:0]  rd_key,
  input  logic [OFFS_W-1:0] rd_offs
);

  typedef enum logic [2:0] {S_IDLE, S_FIRST, S_LAST, S_PROBE, S_DONE} state_t;

  state_t                  state_r, state_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [SW-1:0]           lo_r, lo_nxt;
  logic [SW-1:0]           hi_r, hi_nxt;
  logic [SW-1:0]           mid_r, mid_nxt;
  logic [AW-1:0]           last_r, last_nxt;
  out_word_t               res_r, res_nxt;

  logic          accept;
  logic [SW-1:0] size_c;
  logic          probe_lt;
  logic          probe_gt;
  logic [SW-1:0] nlo, nhi;
  logic [SW-1:0] mid_first, mid_next;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res_word  = res_r;

  assign size_c = (32'(table_size) > 32'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(table_size);

  assign probe_lt  = $signed(rd_key) < key_r;
  assign probe_gt  = $signed(rd_key) > key_r;
  assign nlo       = probe_lt ? (mid_r + SW'(1)) : lo_r;
  assign nhi       = probe_lt ? hi_r : mid_r;
  // hi is exclusive: mid = lo + (hi - 1 - lo) / 2
  assign mid_first = lo_r + ((hi_r - lo_r - SW'(1)) >> 1);
  assign mid_next  = nlo + ((nhi - nlo - SW'(1)) >> 1);

  assign wr_addr = AW'(in_word.slot);
  assign wr_key  = in_word.search_key;
  assign wr_offs = in_word.entry_offset;

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.cmd == CMD_LOAD) begin
            wr_en = 32'(in_word.slot) < 32'(TABLE_DEPTH);
          end else begin
            key_nxt  = in_word.search_key;
            lo_nxt   = '0;
            hi_nxt   = size_c;
            last_nxt = AW'(size_c - SW'(1));
            if (size_c == '0) begin
              res_nxt   = '0;
              state_nxt = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        if (probe_gt) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = last_r;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (probe_lt) begin
          res_nxt.found        = 1'b0;
          res_nxt.position     = POS_W'(hi_r);
          res_nxt.match_offset = '0;
          state_nxt            = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(mid_first);
          mid_nxt   = mid_first;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!probe_lt && !probe_gt) begin
          res_nxt.found        = 1'b1;
          res_nxt.position     = POS_W'(mid_r);
          res_nxt.match_offset = rd_offs;
          state_nxt            = S_DONE;
        end else begin
          lo_nxt = nlo;
          hi_nxt = nhi;
          if (nlo < nhi) begin
            rd_en   = 1'b1;
            rd_addr = AW'(mid_next);
            mid_nxt = mid_next;
          end else begin
            res_nxt.found        = 1'b0;
            res_nxt.position     = POS_W'(nlo);
            res_nxt.match_offset = '0;
            state_nxt            = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    key_r  <= key_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

endmodule

/* hw/rtl/sorted_index_binary_search.sv */
// Sorted key table with binary search lookup; top level.
// Input channel in_valid/in_ready carries one in_word_t word: cmd selects a
// slot load (no result) or a lookup (one result word on out_valid/out_ready).
// cfg_wr_en/cfg_wr_data write table_size, the number of sorted slots in use;
// write it only while no lookup is in flight.
// A load is written to the key memory when it is accepted. A lookup holds
// the input side for its whole search: accept, check slot 0, check the last
// slot, then the search steps (at most clog2(table_size+1) of them), then
// hand the result to the output register. The pace is one read of the key
// memory per step.
// A key outside the stored range finishes after the end checks.
// Reset returns the sequencer to idle and clears out_valid and table_size to 0;
// memory contents are not cleared, and a lookup must only reach loaded slots.
// When the receiver stalls, the finished word waits in the output register
// while the next word can be taken; a further lookup waits at its end.
module sorted_index_binary_search import sibs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);

  logic [SIZE_W-1:0] table_size_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic              res_valid, res_ready;
  out_word_t         res_word;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [KEY_W-1:0]  wr_key, rd_key;
  logic [OFFS_W-1:0] wr_offs, rd_offs;

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size_r <= cfg_wr_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      out_word_r <= res_word;
    end
  end

  sibs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .SW         (SW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .table_size(table_size_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_offs   (wr_offs),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_offs   (rd_offs)
  );

  sibs_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_key (wr_key),
    .wr_offs(wr_offs),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_key (rd_key),
    .rd_offs(rd_offs)
  );

endmodule

/* sim/tb_sorted_index_binary_search.sv */
// Self-checking testbench for sorted_index_binary_search: table loads, lookups and size changes.
`timescale 1ns / 1ps

module tb_sorted_index_binary_search;
  import sibs_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int          DRAIN_CYC   = 32;
  localparam int          LONG_HOLD   = 300;
  localparam int          STALL_LIMIT = 2000;
  localparam int unsigned RAND_WORDS  = 220;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    in_word_t          word;
    logic [SIZE_W-1:0] size;
    logic              typed;
    out_word_t         res;
  } stim_row_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_word_t          in_word     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_word_t         out_word;
  logic              cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;

  // predictor state
  logic signed [KEY_W-1:0] key_mem  [DEPTH];
  logic [OFFS_W-1:0]       offs_mem [DEPTH];
  logic [SIZE_W-1:0]       size_q = '0;

  out_word_t   pending_results [$];
  int          mismatch_cnt = 0;
  int unsigned words_sent   = 0;
  int          quiet_cyc    = 0;
  bit          idle_en      = 1'b1;
  bit          hold_req     = 1'b0;

  sorted_index_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_word_t search_table(input logic signed [KEY_W-1:0] key);
    out_word_t   r;
    int unsigned n;
    int          lo, hi, mid;
    r = '0;
    n = (size_q > DEPTH) ? DEPTH : size_q;
    if (n == 0 || key < key_mem[0]) return r;
    if (key > key_mem[n-1]) begin
      r.position = POS_W'(n);
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_mem[mid] == key) begin
        r.found        = 1'b1;
        r.position     = POS_W'(mid);
        r.match_offset = offs_mem[mid];
        return r;
      end else if (key_mem[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    r.position = POS_W'(lo);
    return r;
  endfunction

  // hits, near misses, both ends and noise; n = slots known to be loaded
  function automatic logic signed [KEY_W-1:0] pick_key(input int unsigned n);
    int unsigned i;
    i = (n == 0) ? 0 : $urandom_range(0, n - 1);
    if (n == 0) return $urandom_range(0, 1) ? $urandom : KEY_MAX;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return key_mem[i];
      4:          return key_mem[i] + 1;
      5:          return key_mem[i] - 1;
      6:          return key_mem[0] - 1;
      7:          return key_mem[n-1] + 1;
      8:          return $urandom;
      default:    return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [SIZE_W-1:0] size);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.size = size;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic cmd, input logic [SLOT_W-1:0] slot,
                                         input logic signed [KEY_W-1:0] key,
                                         input logic [OFFS_W-1:0] offs);
    stim_row_t r;
    r                   = '0;
    r.kind              = ROW_WORD;
    r.word.cmd          = cmd;
    r.word.slot         = slot;
    r.word.search_key   = key;
    r.word.entry_offset = offs;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic signed [KEY_W-1:0] key,
                                            input logic found, input logic [POS_W-1:0] pos,
                                            input logic [OFFS_W-1:0] moff);
    stim_row_t r;
    r                  = item_row(CMD_LOOKUP, '1, key, '1);
    r.typed            = 1'b1;
    r.res.found        = found;
    r.res.position     = pos;
    r.res.match_offset = moff;
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t fixed);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.cmd == CMD_LOAD) begin
      key_mem[w.slot]  = w.search_key;
      offs_mem[w.slot] = w.entry_offset;
    end else begin
      pending_results.push_back(typed ? fixed : search_table(w.search_key));
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    size_q = v;
  endtask

  // ascending keys into slots 0..n-1, repeats allowed
  task automatic load_sorted(input int unsigned n);
    longint          step_max, span, k;
    longint unsigned r;
    in_word_t        w;
    step_max = $urandom_range(0, 1) ? 3 : (longint'(1) << $urandom_range(2, 21));
    span     = 64'd4294967295 - longint'(n) * step_max;
    r        = {$urandom, $urandom};
    k        = longint'(r % longint'(span + 1)) - 64'sd2147483648;
    for (int unsigned s = 0; s < n; s++) begin
      w.cmd          = CMD_LOAD;
      w.slot         = SLOT_W'(s);
      w.search_key   = k[KEY_W-1:0];
      w.entry_offset = $urandom;
      send_word(w, 1'b0, '0);
      k += $urandom_range(0, int'(step_max));
    end
  endtask

  task automatic random_item(input int unsigned n);
    in_word_t w;
    w.slot         = SLOT_W'($urandom_range(0, DEPTH - 1));
    w.entry_offset = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      w.cmd        = CMD_LOAD;
      w.search_key = $urandom;
    end else begin
      w.cmd        = CMD_LOOKUP;
      w.search_key = pick_key(n);
    end
    send_word(w, 1'b0, '0);
  endtask

  always begin : rx_pace
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_ready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, got %h", $time, out_word);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.found !== want.found) begin
          $display("%0t: found, expected %0b, got %0b", $time, want.found, out_word.found);
          mismatch_cnt++;
        end
        if (out_word.position !== want.position) begin
          $display("%0t: position, expected %0d, got %0d", $time, want.position,
                   out_word.position);
          mismatch_cnt++;
        end
        if (out_word.match_offset !== want.match_offset) begin
          $display("%0t: match_offset, expected %h, got %h", $time, want.match_offset,
                   out_word.match_offset);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   dir_tab [$];
    int unsigned n;
    int unsigned phase;

    // empty table right after reset
    dir_tab.push_back(checked_row(32'sd0, 1'b0, 0, 0));
    dir_tab.push_back(checked_row(KEY_MAX, 1'b0, 0, 0));
    dir_tab.push_back(item_row(CMD_LOAD, 0, -32'sd1000, 32'h0000_0000));
    dir_tab.push_back(item_row(CMD_LOAD, 1, -32'sd1, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(CMD_LOAD, 2, 32'sd0, 32'h1234_5678));
    dir_tab.push_back(item_row(CMD_LOAD, 3, 32'sd5, 32'h0000_00A5));
    dir_tab.push_back(item_row(CMD_LOAD, 4, KEY_MAX, 32'hDEAD_BEEF));
    dir_tab.push_back(item_row(CMD_LOAD, '1, KEY_MIN, 32'h8000_0001));
    dir_tab.push_back(cfg_row(5));
    dir_tab.push_back(checked_row(KEY_MIN, 1'b0, 0, 0));
    dir_tab.push_back(checked_row(KEY_MAX, 1'b1, 4, 32'hDEAD_BEEF));
    dir_tab.push_back(item_row(CMD_LOOKUP, 0, -32'sd1000, 0));
    dir_tab.push_back(item_row(CMD_LOOKUP, 0, 32'sd3, 0));
    dir_tab.push_back(item_row(CMD_LOOKUP, 0, -32'sd1, 0));
    dir_tab.push_back(item_row(CMD_LOOKUP, '1, 32'sd0, '1));
    dir_tab.push_back(item_row(CMD_LOOKUP, 7, -32'sd2, 0));
    dir_tab.push_back(cfg_row(1));
    dir_tab.push_back(item_row(CMD_LOOKUP, 0, -32'sd1000, 0));
    dir_tab.push_back(checked_row(32'sd9, 1'b0, 1, 0));
    dir_tab.push_back(checked_row(-32'sd2000, 1'b0, 0, 0));
    dir_tab.push_back(cfg_row(0));
    dir_tab.push_back(checked_row(KEY_MIN, 1'b0, 0, 0));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_size(dir_tab[i].size);
      else send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
    end

    // short tables, rebuilt each pass
    phase = 0;
    words_sent = 0;
    while (words_sent < RAND_WORDS) begin
      idle_en = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = $urandom_range(13, 64);
        default: n = $urandom_range(1, 12);
      endcase
      write_size(SIZE_W'(n));
      load_sorted(n);
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(8, 30)) random_item(n);
      phase++;
    end

    // full depth, oversized size, one short of full
    idle_en = 1'b1;
    write_size(SIZE_W'(DEPTH));
    load_sorted(DEPTH);
    repeat (40) random_item(DEPTH);
    write_size('1);
    repeat (30) random_item(DEPTH);
    write_size(SIZE_W'(DEPTH - 1));
    repeat (20) random_item(DEPTH - 1);

    idle_en = 1'b0;
    write_size(SIZE_W'(DEPTH));
    repeat (40) random_item(DEPTH);

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
